/* src/msps_pkg.sv */
// Package for the maze shortest-path search block: sizes, codes and state encoding.
`default_nettype none
package msps_pkg;
  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W = 3;
  localparam int COL_W = 3;
  localparam int CELL_W = ROW_W + COL_W;
  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int DIST_W = 7;
  localparam logic [DIST_W-1:0] UNREACHED = '1;

  localparam logic [2:0] REG_GRID_ROWS = 3'd0;
  localparam logic [2:0] REG_GRID_COLS = 3'd1;
  localparam logic [2:0] REG_START_ROW = 3'd2;
  localparam logic [2:0] REG_START_COL = 3'd3;
  localparam logic [2:0] REG_END_ROW   = 3'd4;
  localparam logic [2:0] REG_END_COL   = 3'd5;

  localparam logic CMD_WRITE_ROW = 1'b0;
  localparam logic CMD_SOLVE     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_POP,
    ST_POP_WAIT,
    ST_NBR,
    ST_WALK,
    ST_WALK_WAIT,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

/* src/maze_shortest_path_search.sv */
// Maze shortest-path search: wall grid, BFS distance map and greedy path walk.
// Row writes are taken one per cycle while idle and no result is held back by
// out_ready. A solve runs a clearing pass over the 64-entry distance memory, then a
// breadth-first sweep from the end cell through one shared neighbor/compare unit,
// testing each neighbor of every reached cell, then walks from the start cell,
// trying directions in order at each step, and sends one path cell per accepted
// result. in_ready is low while a solve runs.
`default_nettype none
module maze_shortest_path_search (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_command,
  input  wire logic [2:0] in_row_index,
  input  wire logic [7:0] in_wall_bits,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_found,
  output logic [2:0] out_cell_row,
  output logic [2:0] out_cell_col,
  output logic      out_last,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [3:0] cfg_wdata
);
  import msps_pkg::*;

  logic [3:0] rows_r, cols_r;
  logic [2:0] sr_r, sc_r, er_r, ec_r;
  logic [MAX_COLS-1:0] wall_r [MAX_ROWS];

  state_t state_r, state_nxt;

  // distance map memory and the BFS queue memory (also holds the path)
  logic [DIST_W-1:0] dist_mem [NCELLS];
  logic [CELL_W-1:0] queue_mem [NCELLS];
  logic [DIST_W-1:0] dist_rd_r;
  logic [CELL_W-1:0] queue_rd_r;

  logic [6:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [5:0] clr_r, clr_nxt;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic [DIST_W-1:0] curd_r, curd_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [6:0] plen_r, plen_nxt;
  logic [6:0] ecnt_r, ecnt_nxt;
  logic       miss_r, miss_nxt;

  logic       dwe, qwe;
  logic [CELL_W-1:0] dwa, dra, qwa, qra;
  logic [DIST_W-1:0] dwd;
  logic [CELL_W-1:0] qwd;

  logic [3:0] eff_rows, eff_cols;
  assign eff_rows = (rows_r > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_r;
  assign eff_cols = (cols_r > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cols_r;

  function automatic logic is_open(input logic [3:0] r, input logic [3:0] c,
                                   input logic [3:0] nr, input logic [3:0] nc,
                                   input logic [MAX_COLS-1:0] w);
    is_open = (r < nr) && (c < nc) && !w[c[2:0]];
  endfunction

  // shared neighbor unit
  logic [3:0] nb_r, nb_c;
  logic       nb_ok;
  always_comb begin
    nb_r = {1'b0, cur_r[5:3]};
    nb_c = {1'b0, cur_r[2:0]};
    unique case (dir_r)
      2'd0: nb_r = {1'b0, cur_r[5:3]} - 4'd1;
      2'd1: nb_c = {1'b0, cur_r[2:0]} + 4'd1;
      2'd2: nb_r = {1'b0, cur_r[5:3]} + 4'd1;
      2'd3: nb_c = {1'b0, cur_r[2:0]} - 4'd1;
      default: ;
    endcase
    nb_ok = is_open(nb_r, nb_c, eff_rows, eff_cols, wall_r[nb_r[2:0]]);
  end
  logic [CELL_W-1:0] nb_cell;
  assign nb_cell = {nb_r[2:0], nb_c[2:0]};

  logic s_open, e_open;
  assign s_open = is_open({1'b0, sr_r}, {1'b0, sc_r}, eff_rows, eff_cols, wall_r[sr_r]);
  assign e_open = is_open({1'b0, er_r}, {1'b0, ec_r}, eff_rows, eff_cols, wall_r[er_r]);

  // registered result
  logic ov_r, ov_nxt, of_r, of_nxt, ol_r, ol_nxt;
  logic [CELL_W-1:0] oc_r, oc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 4'd8; cols_r <= 4'd8;
      sr_r <= '0; sc_r <= '0; er_r <= 3'd7; ec_r <= 3'd7;
      for (int i = 0; i < MAX_ROWS; i++) wall_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_ROWS: rows_r <= cfg_wdata;
          REG_GRID_COLS: cols_r <= cfg_wdata;
          REG_START_ROW: sr_r <= cfg_wdata[2:0];
          REG_START_COL: sc_r <= cfg_wdata[2:0];
          REG_END_ROW:   er_r <= cfg_wdata[2:0];
          REG_END_COL:   ec_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready && in_command == CMD_WRITE_ROW)
        wall_r[in_row_index] <= in_wall_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (dwe) dist_mem[dwa] <= dwd;
    dist_rd_r <= dist_mem[dra];
    if (qwe) queue_mem[qwa] <= qwd;
    queue_rd_r <= queue_mem[qra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      head_r <= '0; tail_r <= '0; clr_r <= '0; dir_r <= '0;
      plen_r <= '0; ecnt_r <= '0; miss_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; clr_r <= clr_nxt; dir_r <= dir_nxt;
      plen_r <= plen_nxt; ecnt_r <= ecnt_nxt; miss_r <= miss_nxt;
    end
  end
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; curd_r <= curd_nxt;
    of_r <= of_nxt; ol_r <= ol_nxt; oc_r <= oc_nxt;
  end

  logic [CELL_W-1:0] start_cell, end_cell;
  assign start_cell = {sr_r, sc_r};
  assign end_cell = {er_r, ec_r};

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; tail_nxt = tail_r; clr_nxt = clr_r; dir_nxt = dir_r;
    cur_nxt = cur_r; curd_nxt = curd_r; plen_nxt = plen_r; ecnt_nxt = ecnt_r;
    miss_nxt = miss_r;
    ov_nxt = ov_r; of_nxt = of_r; ol_nxt = ol_r; oc_nxt = oc_r;
    dwe = 1'b0; dwa = '0; dwd = '0; dra = nb_cell;
    qwe = 1'b0; qwa = '0; qwd = '0; qra = head_r[5:0];
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !ov_r || out_ready;
        if (in_valid && in_ready && in_command == CMD_SOLVE) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!s_open || !e_open) begin
          miss_nxt = 1'b1; state_nxt = ST_EMIT;
        end else begin
          clr_nxt = '0; state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        dwe = 1'b1; dwa = clr_r; dwd = UNREACHED;
        clr_nxt = clr_r + 6'd1;
        if (clr_r == 6'(NCELLS - 1)) begin
          state_nxt = ST_POP;
          head_nxt = '0; tail_nxt = 7'd1;
          qwe = 1'b1; qwa = '0; qwd = end_cell;
        end
      end
      ST_POP: begin
        // first pop also seeds the end distance
        if (head_r == '0) begin
          dwe = 1'b1; dwa = end_cell; dwd = '0;
        end
        if (head_r == tail_r) begin
          state_nxt = ST_WALK;
          cur_nxt = start_cell; plen_nxt = '0; dir_nxt = '0;
        end else begin
          qra = head_r[5:0];
          state_nxt = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cur_nxt = queue_rd_r;
        dra = queue_rd_r;
        dir_nxt = '0;
        state_nxt = ST_NBR;
        head_nxt = head_r + 7'd1;
        miss_nxt = 1'b1; // current distance read pending
      end
      ST_NBR: begin
        // miss_r: first cycle, latch current distance from read
        if (miss_r) begin
          curd_nxt = dist_rd_r; miss_nxt = 1'b0; dra = nb_cell;
        end else begin
          if (nb_ok && dist_rd_r == UNREACHED && nb_cell != end_cell) begin
            dwe = 1'b1; dwa = nb_cell; dwd = curd_r + 7'd1;
            qwe = 1'b1; qwa = tail_r[5:0]; qwd = nb_cell;
            tail_nxt = tail_r + 7'd1;
          end
          dir_nxt = dir_r + 2'd1;
          if (dir_r == 2'd3) state_nxt = ST_POP;
          else begin
            dra = {cur_r[5:3], cur_r[2:0]}; // re-read current cell distance next
            state_nxt = ST_NBR; miss_nxt = 1'b0;
            // neighbor address for next dir computed next cycle; one idle read
            miss_nxt = 1'b1;
            curd_nxt = curd_r;
          end
        end
        if (miss_r) dra = nb_cell;
        else if (dir_r != 2'd3) dra = cur_r;
      end
      ST_WALK: begin
        dra = (plen_r == '0) ? start_cell : nb_cell;
        state_nxt = ST_WALK_WAIT;
      end
      ST_WALK_WAIT: begin
        if (plen_r == '0) begin
          if (dist_rd_r == UNREACHED && start_cell != end_cell) begin
            miss_nxt = 1'b1; state_nxt = ST_EMIT;
          end else begin
            curd_nxt = (start_cell == end_cell) ? '0 : dist_rd_r;
            qwe = 1'b1; qwa = '0; qwd = start_cell;
            plen_nxt = 7'd1; dir_nxt = '0;
            miss_nxt = 1'b0;
            state_nxt = (start_cell == end_cell) ? ST_EMIT : ST_WALK;
            ecnt_nxt = '0;
          end
        end else if (nb_ok && (dist_rd_r + 7'd1 == curd_r ||
                               (nb_cell == end_cell && curd_r == 7'd1))) begin
          qwe = 1'b1; qwa = plen_r[5:0]; qwd = nb_cell;
          plen_nxt = plen_r + 7'd1;
          cur_nxt = nb_cell; curd_nxt = curd_r - 7'd1; dir_nxt = '0;
          state_nxt = (nb_cell == end_cell) ? ST_EMIT : ST_WALK;
          ecnt_nxt = '0;
        end else begin
          dir_nxt = dir_r + 2'd1;
          state_nxt = ST_WALK;
        end
        qra = '0;
      end
      ST_EMIT: begin
        qra = ecnt_r[5:0];
        if (!ov_r || out_ready) begin
          if (miss_r) begin
            ov_nxt = 1'b1; of_nxt = 1'b0; oc_nxt = '0; ol_nxt = 1'b1;
            miss_nxt = 1'b0; state_nxt = ST_IDLE;
          end else if (ecnt_r[6] == 1'b0 && ecnt_r != 7'h7f && dir_r == 2'd0) begin
            dir_nxt = 2'd1; // read issued
          end else begin
            ov_nxt = 1'b1; of_nxt = 1'b1; oc_nxt = queue_rd_r;
            ol_nxt = (ecnt_r + 7'd1 == plen_r);
            ecnt_nxt = ecnt_r + 7'd1; dir_nxt = '0;
            qra = ecnt_r[5:0] + 6'd1;
            if (ecnt_r + 7'd1 == plen_r) state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_found = of_r;
  assign out_cell_row = oc_r[5:3];
  assign out_cell_col = oc_r[2:0];
  assign out_last = ol_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(oc_r))) else $error("result dropped");
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last) else $error("not-found without last");
endmodule
`default_nettype wire

/* tb/maze_path_checker.sv */
// Checker for the maze search block: predicts solve results and compares each path cell.
`default_nettype none
module maze_path_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       in_command,
  input  wire logic [2:0] in_row_index,
  input  wire logic [7:0] in_wall_bits,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       out_found,
  input  wire logic [2:0] out_cell_row,
  input  wire logic [2:0] out_cell_col,
  input  wire logic       out_last,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [3:0] cfg_wdata,
  output int              fail_count,
  output int              pending_cells,
  output int              cells_seen,
  output int              solves_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import msps_pkg::*;

  typedef struct packed {
    logic       found;
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } path_cell_t;

  path_cell_t expected_cells[$];
  logic [7:0] walls[MAX_ROWS];
  logic [3:0] rows_cfg, cols_cfg;
  logic [2:0] sr_cfg, sc_cfg, er_cfg, ec_cfg;

  function automatic bit open_cell(int r, int c);
    int nr, nc;
    nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 0;
    return !walls[r][c];
  endfunction

  // Shortest path with up/right/down/left tie-break: BFS distances from the end,
  // then a greedy walk from the start.
  task automatic predict_solve();
    int dmap[NCELLS];
    int fifo[$];
    int dr[4], dc[4];
    int r, c, nr, nc, cur_idx, d, here, len;
    path_cell_t pc;
    dr = '{-1, 0, 1, 0};
    dc = '{0, 1, 0, -1};
    if (!open_cell(sr_cfg, sc_cfg) || !open_cell(er_cfg, ec_cfg)) begin
      pc = '{1'b0, 3'd0, 3'd0, 1'b1};
      expected_cells.push_back(pc);
      return;
    end
    foreach (dmap[i]) dmap[i] = -1;
    dmap[er_cfg * MAX_COLS + ec_cfg] = 0;
    fifo.push_back(er_cfg * MAX_COLS + ec_cfg);
    while (fifo.size() > 0) begin
      cur_idx = fifo.pop_front();
      r = cur_idx / MAX_COLS;
      c = cur_idx % MAX_COLS;
      for (d = 0; d < 4; d++) begin
        nr = r + dr[d];
        nc = c + dc[d];
        if (open_cell(nr, nc) && dmap[nr * MAX_COLS + nc] < 0) begin
          dmap[nr * MAX_COLS + nc] = dmap[cur_idx] + 1;
          fifo.push_back(nr * MAX_COLS + nc);
        end
      end
    end
    if (dmap[sr_cfg * MAX_COLS + sc_cfg] < 0) begin
      pc = '{1'b0, 3'd0, 3'd0, 1'b1};
      expected_cells.push_back(pc);
      return;
    end
    r = sr_cfg;
    c = sc_cfg;
    len = dmap[r * MAX_COLS + c] + 1;
    for (int k = 0; k < len; k++) begin
      pc = '{1'b1, r[2:0], c[2:0], k == len - 1};
      expected_cells.push_back(pc);
      here = dmap[r * MAX_COLS + c];
      for (d = 0; d < 4; d++) begin
        nr = r + dr[d];
        nc = c + dc[d];
        if (open_cell(nr, nc) && dmap[nr * MAX_COLS + nc] + 1 == here) break;
      end
      r = nr;
      c = nc;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    path_cell_t got, want;
    if (!rst_n) begin
      foreach (walls[i]) walls[i] = '0;
      rows_cfg = 4'd8; cols_cfg = 4'd8;
      sr_cfg = '0; sc_cfg = '0; er_cfg = 3'd7; ec_cfg = 3'd7;
      expected_cells.delete();
      fail_count = 0; pending_cells = 0; cells_seen = 0; solves_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_ROWS: rows_cfg = cfg_wdata;
          REG_GRID_COLS: cols_cfg = cfg_wdata;
          REG_START_ROW: sr_cfg = cfg_wdata[2:0];
          REG_START_COL: sc_cfg = cfg_wdata[2:0];
          REG_END_ROW:   er_cfg = cfg_wdata[2:0];
          REG_END_COL:   ec_cfg = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_found, out_cell_row, out_cell_col, out_last};
        cells_seen++;
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = expected_cells.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
          if (got.row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
          if (got.col !== want.col)
            report_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_SOLVE) begin
          predict_solve();
          solves_seen++;
        end else begin
          walls[in_row_index] = in_wall_bits;
        end
      end
      pending_cells = expected_cells.size();
    end
  end
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench top: drives row writes, solves and register settings into the maze search block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msps_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_command = 0;
  logic [2:0] in_row_index = 0;
  logic [7:0] in_wall_bits = 0;
  logic out_ready = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [3:0] cfg_wdata = 0;
  wire logic in_ready, out_valid, out_found, out_last;
  wire logic [2:0] out_cell_row, out_cell_col;
  int fail_count, pending_cells, cells_seen, solves_seen;
  int idle_cycles = 0;
  int hold_off = 0;
  bit stall_mode = 0;

  maze_shortest_path_search dut (.*);
  maze_path_checker chk (.*);

  initial forever #4 clk = ~clk;

  // Receiver: own stall pattern plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (stall_mode) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [2:0] row, logic [7:0] bits);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_row_index <= row;
    in_wall_bits <= bits;
    // in_ready only moves at the rising edge, so look at it mid-cycle
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cells != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_maze(int rows, int cols, int sr, int sc, int er, int ec);
    write_reg(REG_GRID_ROWS, 4'(rows));
    write_reg(REG_GRID_COLS, 4'(cols));
    write_reg(REG_START_ROW, 4'(sr));
    write_reg(REG_START_COL, 4'(sc));
    write_reg(REG_END_ROW, 4'(er));
    write_reg(REG_END_COL, 4'(ec));
    cfg_we <= 1'b0;
  endtask

  // Sparse walls keep most mazes solvable.
  function automatic logic [7:0] sparse_walls();
    logic [7:0] w;
    w = 8'($urandom & $urandom);
    if ($urandom_range(0, 7) == 0) w = 8'($urandom);
    return w;
  endfunction

  initial begin
    int burst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty 8x8 corner to corner, walls at extremes, special cases.
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    send_request(CMD_WRITE_ROW, 3'd7, 8'hFF);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    send_request(CMD_WRITE_ROW, 3'd7, 8'h00);
    send_request(CMD_WRITE_ROW, 3'd3, 8'hFE);
    send_request(CMD_WRITE_ROW, 3'd5, 8'h7F);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    send_request(CMD_WRITE_ROW, 3'd0, 8'h01);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    send_request(CMD_WRITE_ROW, 3'd0, 8'h00);
    drain();
    set_maze(8, 8, 7, 7, 0, 0);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    drain();
    set_maze(1, 1, 0, 0, 0, 0);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    drain();
    set_maze(0, 0, 0, 0, 0, 0);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    drain();
    set_maze(15, 15, 3, 3, 3, 3);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    drain();
    set_maze(4, 8, 0, 0, 5, 2);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    drain();
    // Long receiver hold-off while requests keep coming.
    set_maze(8, 8, 0, 0, 7, 7);
    hold_off = 300;
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    send_request(CMD_WRITE_ROW, 3'd2, 8'hAA);
    send_request(CMD_SOLVE, 3'd0, 8'd0);
    send_request(CMD_WRITE_ROW, 3'd2, 8'h55);
    drain();

    // Random phases: new geometry each phase, bursts of row writes and solves.
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) set_maze(8, 8, 0, 0, 7, 7);
      else set_maze($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
      for (int n = 0; n < 12; n += burst) begin
        burst = $urandom_range(1, 4);
        for (int b = 0; b < burst; b++) begin
          if ($urandom_range(0, 3) == 0) send_request(CMD_SOLVE, 3'($urandom), 8'($urandom));
          else send_request(CMD_WRITE_ROW, 3'($urandom), sparse_walls());
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      send_request(CMD_SOLVE, 3'd0, 8'd0);
      drain();
    end

    $display("covered %0d solves, %0d path cells checked, incl. bad endpoints and sizes",
             solves_seen, cells_seen);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
src/msps_pkg.sv
src/maze_shortest_path_search.sv
tb/maze_path_checker.sv
tb/testbench.sv
